FILE: rtl/binary_to_decimal_128_core_defines.svh
// Assertion macros used by the port checker of the decimal formatter.
`ifndef BINARY_TO_DECIMAL_128_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_128_CORE_DEFINES_SVH

// Check a condition in the cycle after a trigger.
`define B2D_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("b2d check failed");

// Check a condition in the same cycle as a trigger.
`define B2D_ASSERT_SAME(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("b2d check failed");

`endif

FILE: rtl/b2d_pkg.sv
// Types and constants shared by the decimal formatter modules.
`timescale 1ns / 1ps
package b2d_pkg;
	localparam int BIN_W = 128;
	localparam int NDIG = 39;
	localparam int BCD_W = NDIG * 4;
	localparam int BLEN_W = 6;
	localparam int IDX_W = $clog2(NDIG);
	localparam int STAGES = 16;
	localparam int STEPS = BIN_W / STAGES;
	localparam logic [5:0] ASCII_ZERO = 6'd48;
	localparam logic [5:0] CHAR_NUL = 6'd0;

	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [BIN_W-1:0] bin;
		logic [BLEN_W-1:0] blen;
	} b2d_item_t;
endpackage

FILE: rtl/b2d_dabble_stage.sv
// One pipeline stage of the double-dabble converter: a fixed number of shift steps.
`timescale 1ns / 1ps
module b2d_dabble_stage
	import b2d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  b2d_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output b2d_item_t out_item
);
	logic      valid_s1;
	b2d_item_t item_s1;
	b2d_item_t next_item;

	// Run the shift steps: add three to digits of five or more, then shift in one bit.
	always_comb begin
		next_item = in_item;
		for (int k = 0; k < STEPS; k++) begin
			for (int d = 0; d < NDIG; d++) begin
				if (next_item.bcd[d*4 +: 4] >= 4'd5)
					next_item.bcd[d*4 +: 4] = next_item.bcd[d*4 +: 4] + 4'd3;
			end
			next_item.bcd = {next_item.bcd[BCD_W-2:0], next_item.bin[BIN_W-1]};
			next_item.bin = {next_item.bin[BIN_W-2:0], 1'b0};
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	// Advance the stage whenever it is empty or its content moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= next_item;
		end
	end

	assign out_valid = valid_s1;
	assign out_item = item_s1;
endmodule

FILE: rtl/b2d_emitter.sv
// Serializer that turns a packed BCD value into ASCII characters and a terminator.
`timescale 1ns / 1ps
module b2d_emitter
	import b2d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  b2d_item_t in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output logic [5:0] out_char,
	output logic      out_last
);
	logic              busy_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BLEN_W-1:0] left_q;
	logic              ov_q;
	logic [5:0]        oc_q;
	logic              ol_q;
	logic [BLEN_W-1:0] cnt;
	logic [BLEN_W-1:0] keep;
	logic              advance;

	// Count digits up to the leading nonzero one; zero counts as one digit.
	always_comb begin
		cnt = BLEN_W'(1);
		for (int d = 0; d < NDIG; d++) begin
			if (in_item.bcd[d*4 +: 4] != 4'd0)
				cnt = BLEN_W'(d + 1);
		end
		if (in_item.blen == '0)
			keep = '0;
		else if (cnt >= in_item.blen)
			keep = in_item.blen - BLEN_W'(1);
		else
			keep = cnt;
	end

	assign in_ready = !busy_q;
	assign advance = !ov_q || out_ready;

	// Load a transaction, then emit one character per free output slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (in_valid)
					busy_q <= 1'b1;
				if (advance)
					ov_q <= 1'b0;
			end else if (advance) begin
				ov_q <= 1'b1;
				if (left_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			bcd_q <= in_item.bcd;
			idx_q <= IDX_W'(cnt - BLEN_W'(1));
			left_q <= keep;
		end else if (busy_q && advance) begin
			if (left_q != '0) begin
				oc_q <= ASCII_ZERO + {2'b00, bcd_q[idx_q*4 +: 4]};
				ol_q <= 1'b0;
				idx_q <= idx_q - IDX_W'(1);
				left_q <= left_q - BLEN_W'(1);
			end else begin
				oc_q <= CHAR_NUL;
				ol_q <= 1'b1;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_char = oc_q;
	assign out_last = ol_q;
endmodule

FILE: rtl/binary_to_decimal_128_core.sv
// Top level of the 128-bit binary to decimal text formatter.
// Channel | Dir | Fields
// s_*     | in  | tdata: value_high[63:0], value_low[127:64], buffer_length[133:128]
// m_*     | out | tdata: char_code[5:0]; tlast: is_last
// A transaction passes 16 conversion stages of 8 shift steps each,
// then the serializer emits keep digits plus the terminator, one per cycle while the output accepts them.
// The serializer sets the rate: it loads no new transaction until it has emitted the terminator.
// Reset clears all valid bits; data registers are not reset.
// Stalls on the output back up stage by stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
module binary_to_decimal_128_core
	import b2d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // value_high[63:0], value_low[127:64], buffer_length[133:128]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,  // char_code[5:0]
	output logic         m_tlast   // is_last
);
	logic      vld [STAGES+1];
	logic      rdy [STAGES+1];
	b2d_item_t itm [STAGES+1];
	logic [5:0] char_code;

	// Unpack the input transaction into the converter's first item.
	assign vld[0] = s_tvalid;
	assign s_tready = rdy[0];
	assign itm[0].bcd = '0;
	assign itm[0].bin = {s_tdata[63:0], s_tdata[127:64]};
	assign itm[0].blen = s_tdata[133:128];

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		b2d_dabble_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[g]),
			.in_ready (rdy[g]),
			.in_item  (itm[g]),
			.out_valid(vld[g+1]),
			.out_ready(rdy[g+1]),
			.out_item (itm[g+1])
		);
	end

	b2d_emitter u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld[STAGES]),
		.in_ready (rdy[STAGES]),
		.in_item  (itm[STAGES]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_char (char_code),
		.out_last (m_tlast)
	);

	assign m_tdata = {2'b00, char_code};
endmodule

FILE: rtl/b2d_checker.sv
// Port checker for the decimal formatter, bound to the top level.
`timescale 1ns / 1ps
`include "binary_to_decimal_128_core_defines.svh"
module b2d_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [135:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [7:0]   m_tdata,
	input logic         m_tlast
);
	// Hold a stalled output.
	`B2D_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`B2D_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
	// Digits are ASCII 0..9, the terminator is NUL.
	`B2D_ASSERT_SAME(a_digit, m_tvalid && !m_tlast,
		m_tdata[7:4] == 4'h3 && (m_tdata[3] == 1'b0 || m_tdata[2:1] == 2'b00))
	`B2D_ASSERT_SAME(a_nul, m_tvalid && m_tlast, m_tdata == 8'h00)
endmodule

bind binary_to_decimal_128_core b2d_checker u_chk (.*);

FILE: tb/sv/binary_to_decimal_128_checker.sv
// Scoreboard for the decimal formatter: predicts characters and compares output.
`timescale 1ns / 1ps
module binary_to_decimal_128_checker
	import b2d_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [7:0]   m_tdata,
	input  logic         m_tlast,
	output int           errors,
	output int           pending,
	output int           chars_seen
);
	typedef struct packed {
		logic [5:0] code;
		logic       last;
	} text_char_t;

	text_char_t text_q[$];

	// Build the decimal text of one value, truncated to the buffer length.
	task automatic format_value(input logic [127:0] value, input logic [5:0] blen);
		logic [3:0] digs[40];
		logic [127:0] rest;
		int cnt;
		int keep;
		text_char_t c;
		rest = value;
		cnt = 0;
		if (rest == 0) begin
			digs[0] = 0;
			cnt = 1;
		end
		while (rest != 0 && cnt < 40) begin
			digs[cnt] = 4'(rest % 10);
			rest = rest / 10;
			cnt++;
		end
		if (blen == 0)
			keep = 0;
		else if (cnt >= blen)
			keep = blen - 1;
		else
			keep = cnt;
		for (int k = 0; k < keep; k++) begin
			c.code = ASCII_ZERO + 6'(digs[cnt - 1 - k]);
			c.last = 1'b0;
			text_q.push_back(c);
		end
		c.code = CHAR_NUL;
		c.last = 1'b1;
		text_q.push_back(c);
	endtask

	// Predict on input transactions, compare on output transactions.
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			errors <= 0;
			chars_seen <= 0;
		end else begin
			if (s_tvalid && s_tready)
				format_value({s_tdata[63:0], s_tdata[127:64]}, s_tdata[133:128]);
			if (m_tvalid && m_tready) begin
				chars_seen <= chars_seen + 1;
				if (text_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected char %0d last %0d", m_tdata[5:0], m_tlast);
					errors <= errors + 1;
				end else begin
					want = text_q.pop_front();
					if (want.code !== m_tdata[5:0] || want.last !== m_tlast) begin
						if (errors < 10)
							$display("mismatch: expected char %0d last %0d, got %0d last %0d",
								want.code, want.last, m_tdata[5:0], m_tlast);
						errors <= errors + 1;
					end
				end
			end
		end
	end

	assign pending = text_q.size();
endmodule

FILE: tb/sv/binary_to_decimal_128_core_test.sv
// Testbench top for the decimal formatter: stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module binary_to_decimal_128_core_test;
	import b2d_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [7:0]   m_tdata;
	logic         m_tlast;
	int           errors;
	int           pending;
	int           chars_seen;
	int           values_sent;
	bit           hold_off;

	binary_to_decimal_128_core dut (.*);

	binary_to_decimal_128_checker scoreboard (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one, sometimes none.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Random value whose magnitude spans every decimal length.
	function automatic logic [127:0] random_value();
		logic [127:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		return v >> $urandom_range(0, 127);
	endfunction

	// Offer one value and hold it until the transaction completes.
	task automatic send_value(input logic [127:0] value, input logic [5:0] blen);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, blen, value[63:0], value[127:64]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		values_sent++;
	endtask

	// Output readiness: random stalls, plus one long hold-off on request.
	initial begin
		int g;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			m_tready <= 1'b1;
			@(posedge clk);
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	initial begin
		logic [127:0] v;
		logic [127:0] p10;
		int wait_cnt;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_off = 1'b0;
		values_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, all ones, powers of ten, buffer extremes and truncation.
		send_value(128'd0, 6'd1);
		send_value(128'd0, 6'd40);
		send_value('1, 6'd40);
		send_value('1, 6'd39);
		send_value('1, 6'd1);
		send_value('1, 6'd63);
		send_value('1, 6'd0);
		send_value(128'd0, 6'd0);
		send_value(128'd9, 6'd2);
		send_value(128'd10, 6'd2);
		send_value(128'd12345, 6'd3);
		send_value({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 6'd21);
		send_value({64'h1, 64'h0}, 6'd40);
		send_value({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 6'd40);
		p10 = 1;
		for (int k = 0; k < 38; k += 4) begin
			send_value(p10, 6'd40);
			send_value(p10 - 1, 6'd40);
			p10 = p10 * 10000;
		end

		// Stall the output while the input keeps offering.
		hold_off = 1'b1;
		for (int i = 0; i < 30; i++)
			send_value(random_value(), 6'($urandom_range(1, 40)));

		// Random: mostly lengths that fit, some that truncate and odd lengths.
		for (int i = 0; i < 430; i++) begin
			v = ($urandom_range(0, 9) == 0) ? 128'($urandom_range(0, 20)) : random_value();
			case ($urandom_range(0, 9))
				0: send_value(v, 6'($urandom));
				1, 2: send_value(v, 6'($urandom_range(1, 12)));
				default: send_value(v, 6'd40);
			endcase
		end
		s_tvalid <= 1'b0;

		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d values, checked %0d characters including terminators.",
			values_sent, chars_seen);
		$display("Covered zero, full-scale, powers of ten, truncation and a long output stall.");
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#60ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
